@@ sv/ucbe_pkg.sv @@
// ----------------------------------------------------------------------------
// ucbe_pkg
// Types and codes shared by the uniform cubic B-spline evaluator.
// ----------------------------------------------------------------------------
package ucbe_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int IDX_W       = 16;
    localparam int T_W         = 17;
    localparam int W_W         = 19;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_EVAL   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic CFG_SAMPLE_COUNT = 1'b0;
    localparam logic CFG_CLOSED_MODE  = 1'b1;

    typedef struct packed {
        logic [1:0]                    opcode;
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic [IDX_W-1:0]              sample_index;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] curve_x;
        logic signed [COORD_WIDTH-1:0] curve_y;
        logic [1:0]                    status;
    } t_out_item;

endpackage

@@ sv/ucbe_mul.sv @@
// ----------------------------------------------------------------------------
// ucbe_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ucbe_mul #(
    parameter int A_W = 35,
    parameter int B_W = 20
) (
    input  logic                   i_clk,
    input  logic signed [A_W-1:0]  i_a,
    input  logic signed [B_W-1:0]  i_b,
    output logic signed [A_W+B_W-1:0] o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule

@@ sv/ucbe_div.sv @@
// ----------------------------------------------------------------------------
// ucbe_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ucbe_div #(
    parameter int DV_W = 32,
    parameter int DS_W = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DV_W-1:0] i_dividend,
    input  logic [DS_W-1:0] i_divisor,
    output logic            o_done,
    output logic [DV_W-1:0] o_quot,
    output logic [DS_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(DV_W + 1);

    logic [DS_W-1:0]  r_rem;
    logic [DV_W-1:0]  r_quo;
    logic [DS_W-1:0]  r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DS_W:0]    sh;
    logic [DS_W+1:0]  diff;

    assign sh   = {r_rem, r_quo[DV_W-1]};
    assign diff = {1'b0, sh} - {2'b00, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DV_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                if (diff[DS_W+1]) begin
                    r_rem <= sh[DS_W-1:0];
                    r_quo <= {r_quo[DV_W-2:0], 1'b0};
                end else begin
                    r_rem <= diff[DS_W-1:0];
                    r_quo <= {r_quo[DV_W-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;
endmodule

@@ sv/ucbe_store.sv @@
// ----------------------------------------------------------------------------
// ucbe_store
// Control point memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ucbe_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [2*ucbe_pkg::COORD_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [2*ucbe_pkg::COORD_WIDTH-1:0] o_rdata
);
    import ucbe_pkg::*;

    logic [2*COORD_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

@@ sv/uniform_cubic_bspline_eval_core.sv @@
// ----------------------------------------------------------------------------
// uniform_cubic_bspline_eval_core
// Control point store and uniform cubic B-spline point evaluator.
// ----------------------------------------------------------------------------
// Clear and append are done in S_IDLE. Their result transfer is offered on the
// next cycle. An evaluation runs on one shared multiplier and one bit-per-cycle
// divider by the sample count. The product i*(m-3) is divided first. When the
// remainder is nonzero, it is scaled by 2^16 and divided again to give the
// local parameter. Two multiplier passes give t^2 and t^3, and the four basis
// weights are formed in S_WGT. The four points are blended in S_BLEND. The
// divide by six is two reciprocal multiplications. The result is registered
// in S_DONE; when the sample falls exactly on a knot, the second divide is
// skipped. No new item is taken until the current one is done and its result
// transfer can be made.
module uniform_cubic_bspline_eval_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ucbe_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ucbe_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    import ucbe_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int PW     = $clog2(MAX_POINTS + 1);
    localparam int AW     = $clog2(MAX_POINTS);
    localparam int EW     = PW + 2;
    localparam int NUM_W  = IDX_W + PW;
    localparam int ACC_W  = CW + 22;
    localparam int DV_A   = (NUM_W > 32) ? NUM_W : 32;
    localparam int DV_W   = (DV_A > ACC_W - 16) ? DV_A : ACC_W - 16;
    localparam int DS_W   = 16;
    localparam int MA_W   = 35;
    localparam int MB_W   = 20;
    localparam int MP_W   = MA_W + MB_W;
    localparam int B_W    = 56;
    localparam int RECIP6 = 2796203;
    localparam int RCP_SH = 24;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_MNUM  = 12'b000000000010,
        S_SNUM  = 12'b000000000100,
        S_WNUM  = 12'b000000001000,
        S_WT    = 12'b000000010000,
        S_MT2   = 12'b000000100000,
        S_MT3   = 12'b000001000000,
        S_WGT   = 12'b000010000000,
        S_BLEND = 12'b000100000000,
        S_WX    = 12'b001000000000,
        S_WY    = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } t_state;

    t_state                r_state;
    logic [PW-1:0]         r_cnt;
    logic [15:0]           r_n;
    logic                  r_closed;
    logic [IDX_W-1:0]      r_idx;
    logic [PW-1:0]         r_mm3;
    logic [PW:0]           r_j;
    logic [T_W-1:0]        r_t;
    logic [33:0]           r_t2;
    logic [W_W-1:0]        r_w [4];
    logic [1:0]            r_k;
    logic [1:0]            r_ph;
    logic signed [ACC_W-1:0] r_accx;
    logic signed [ACC_W-1:0] r_accy;
    logic signed [CW-1:0]  r_cx;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;
    logic                   div_start;
    logic [DV_W-1:0]        div_dvd;
    logic [DS_W-1:0]        div_dsr;
    logic                   div_done;
    logic [DV_W-1:0]        div_quo;
    logic [DS_W-1:0]        div_rem;
    logic [2*CW-1:0]        rd_data;
    logic                   acc_in;
    logic                   go_eval;
    logic [1:0]             in_status;
    logic                   few;
    logic                   full;
    logic [EW-1:0]          e_raw;
    logic [EW-1:0]          e_wrap;
    logic [AW-1:0]          raddr;
    logic [ACC_W-1:0]       magx;
    logic [ACC_W-1:0]       magy;
    logic [DV_W-1:0]        q6;
    logic signed [B_W-1:0]  tt;
    logic signed [B_W-1:0]  t2s;
    logic signed [B_W-1:0]  t3s;
    logic signed [B_W-1:0]  b0;
    logic signed [B_W-1:0]  b1;
    logic signed [B_W-1:0]  b2;
    logic signed [B_W-1:0]  b3;
    logic signed [B_W-1:0]  s48;
    logic signed [B_W-1:0]  half;

    function automatic logic [ACC_W-1:0] round_mag(input logic signed [ACC_W-1:0] a);
        logic [ACC_W-1:0] m;
        m = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
        return (m + ACC_W'(196608)) >> 16;
    endfunction

    function automatic logic signed [CW-1:0] sat(input logic neg, input logic [DV_W-1:0] q);
        logic signed [CW-1:0] v;
        if (!neg) begin
            v = (q > DV_W'((1 << (CW - 1)) - 1)) ? CW'((1 << (CW - 1)) - 1) : CW'(q);
        end else begin
            v = (q > DV_W'(1 << (CW - 1))) ? CW'(1 << (CW - 1)) : CW'(-q);
        end
        return v;
    endfunction

    assign acc_in      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign few  = r_closed ? (r_cnt < PW'(3)) : (r_cnt < PW'(4));
    assign full = (r_cnt >= PW'(MAX_POINTS));

    always_comb begin
        in_status = ST_OK;
        case (i_in_data.opcode)
            OP_APPEND: begin
                if (full) begin
                    in_status = ST_FULL;
                end
            end
            OP_EVAL: begin
                if (few) begin
                    in_status = ST_FEW;
                end else if (i_in_data.sample_index >= r_n) begin
                    in_status = ST_RANGE;
                end
            end
            default: begin
                in_status = ST_OK;
            end
        endcase
    end

    assign go_eval = acc_in && (i_in_data.opcode == OP_EVAL) && (in_status == ST_OK);

    assign e_raw  = EW'(r_j) - EW'(1) + EW'(r_k);
    assign e_wrap = (e_raw >= EW'(r_cnt)) ? e_raw - EW'(r_cnt) : e_raw;
    assign raddr  = (e_wrap >= EW'(MAX_POINTS)) ? '0 : e_wrap[AW-1:0];

    assign magx = round_mag(r_accx);
    assign magy = round_mag(r_accy);

    // divide by six through the reciprocal
    assign q6 = DV_W'(mul_p[MP_W-1:RCP_SH]);

    // basis times 6*S^3, exact
    assign tt   = B_W'(r_t);
    assign t2s  = B_W'(r_t2);
    assign t3s  = B_W'(mul_p[50:0]);
    assign s48  = B_W'(1) <<< 48;
    assign half = B_W'(1) <<< 31;
    assign b0 = s48 - 3 * (tt <<< 32) + 3 * (t2s <<< 16) - t3s;
    assign b1 = 3 * t3s - 6 * (t2s <<< 16) + 4 * s48;
    assign b2 = -3 * t3s + 3 * (t2s <<< 16) + 3 * (tt <<< 32) + s48;
    assign b3 = t3s;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MNUM: begin
                mul_a = MA_W'(r_mm3);
                mul_b = MB_W'(r_idx);
            end
            S_MT2: begin
                mul_a = MA_W'(r_t);
                mul_b = MB_W'(r_t);
            end
            S_MT3: begin
                mul_a = MA_W'(mul_p[33:0]);
                mul_b = MB_W'(r_t);
            end
            S_BLEND: begin
                mul_b = MB_W'(r_w[r_k]);
                if (r_ph == 2'd1) begin
                    mul_a = MA_W'(signed'(rd_data[2*CW-1:CW]));
                end else begin
                    mul_a = MA_W'(signed'(rd_data[CW-1:0]));
                end
            end
            S_WX: begin
                mul_a = MA_W'(RECIP6);
                mul_b = MB_W'(magx);
            end
            S_WY: begin
                mul_a = MA_W'(RECIP6);
                mul_b = MB_W'(magy);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dsr   = r_n;
        case (r_state)
            S_SNUM: begin
                div_start = 1'b1;
                div_dvd   = DV_W'(mul_p[NUM_W-1:0]);
            end
            S_WNUM: begin
                div_start = div_done && (div_rem != '0);
                div_dvd   = DV_W'({div_rem, 16'd0});
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    ucbe_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    ucbe_div #(.DV_W(DV_W), .DS_W(DS_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quot     (div_quo),
        .o_rem      (div_rem)
    );

    ucbe_store #(.DEPTH(MAX_POINTS), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (acc_in && i_in_data.opcode == OP_APPEND && !full),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata ({i_in_data.point_x, i_in_data.point_y}),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE) begin
            r_out_valid <= 1'b1;
        end else if (acc_in) begin
            r_out_valid <= !go_eval;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_n         <= 16'd64;
            r_closed    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_SAMPLE_COUNT) begin
                    r_n <= i_cfg_data;
                end else begin
                    r_closed <= i_cfg_data[0];
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        r_out <= '{curve_x: '0, curve_y: '0, status: in_status};
                        r_idx <= i_in_data.sample_index;
                        r_mm3 <= r_closed ? r_cnt : r_cnt - PW'(3);
                        case (i_in_data.opcode)
                            OP_CLEAR: begin
                                r_cnt <= '0;
                            end
                            OP_APPEND: begin
                                if (!full) begin
                                    r_cnt <= r_cnt + 1'b1;
                                end
                            end
                            OP_EVAL: begin
                                if (go_eval) begin
                                    r_state <= S_MNUM;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MNUM: r_state <= S_SNUM;
                S_SNUM: r_state <= S_WNUM;
                S_WNUM: begin
                    if (div_done) begin
                        if (div_rem == '0) begin
                            r_j     <= (div_quo == '0) ? (PW+1)'(1) : div_quo[PW:0];
                            r_t     <= (div_quo == '0) ? '0 : T_W'(65536);
                            r_state <= S_MT2;
                        end else begin
                            r_j     <= div_quo[PW:0] + 1'b1;
                            r_state <= S_WT;
                        end
                    end
                end
                S_WT: begin
                    if (div_done) begin
                        r_t     <= div_quo[T_W-1:0];
                        r_state <= S_MT2;
                    end
                end
                S_MT2: r_state <= S_MT3;
                S_MT3: begin
                    r_t2    <= mul_p[33:0];
                    r_state <= S_WGT;
                end
                S_WGT: begin
                    r_w[0]  <= W_W'((b0 + half) >>> 32);
                    r_w[1]  <= W_W'((b1 + half) >>> 32);
                    r_w[2]  <= W_W'((b2 + half) >>> 32);
                    r_w[3]  <= W_W'((b3 + half) >>> 32);
                    r_accx  <= '0;
                    r_accy  <= '0;
                    r_k     <= '0;
                    r_ph    <= '0;
                    r_state <= S_BLEND;
                end
                S_BLEND: begin
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 2'd2) begin
                        r_accx <= r_accx + ACC_W'(mul_p);
                    end
                    if (r_ph == 2'd3) begin
                        r_accy <= r_accy + ACC_W'(mul_p);
                        r_k    <= r_k + 1'b1;
                        if (r_k == 2'd3) begin
                            r_state <= S_WX;
                        end
                    end
                end
                S_WX: r_state <= S_WY;
                S_WY: begin
                    r_cx    <= sat(r_accx[ACC_W-1], q6);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_out   <= '{curve_x: r_cx, curve_y: sat(r_accy[ACC_W-1], q6),
                                 status: ST_OK};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ dv/uniform_cubic_bspline_eval_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uniform_cubic_bspline_eval_core_tb
// Self-checking bench: control point loads and curve evaluations are compared
// against a built-in B-spline predictor under random idling and back-pressure.
// ----------------------------------------------------------------------------
module uniform_cubic_bspline_eval_core_tb;

    import ucbe_pkg::*;

    localparam int   MAXP        = 64;
    localparam int   CYCLE_LIMIT = 3000000;
    localparam int   N_RANDOM    = 1700;
    localparam logic [63:0] S1   = 64'd65536;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [15:0] i_cfg_data;

    uniform_cubic_bspline_eval_core #(.MAX_POINTS(MAXP)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic signed [15:0] pts_x [MAXP];
    logic signed [15:0] pts_y [MAXP];
    int unsigned        pt_count;
    logic [15:0]        n_samples;
    logic               wrap_mode;

    t_out_item   pending_q[$];
    int          errors;
    int          cycles;
    bit          hold_off;

    // directed rows
    typedef struct {
        t_in_item  item;
        bit        fixed;
        t_out_item result;
    } t_row;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint blend_coord(longint w[4], longint p[4]);
        longint acc;
        longint d;
        acc = 0;
        d = 6 * 65536;
        for (int k = 0; k < 4; k++)
            acc += w[k] * p[k];
        if (acc >= 0)
            return (acc + d / 2) / d;
        return -((-acc + d / 2) / d);
    endfunction

    function automatic t_out_item spline_predict(t_in_item it);
        t_out_item   res;
        logic [63:0] m, num, q, r, j, t, s2, t2, t3, e;
        logic [63:0] b[4];
        longint      w[4], px[4], py[4];
        bit          few;
        res = '0;
        s2 = S1 * S1;
        case (it.opcode)
            OP_CLEAR: pt_count = 0;
            OP_APPEND: begin
                if (pt_count >= MAXP) begin
                    res.status = ST_FULL;
                end else begin
                    pts_x[pt_count] = it.point_x;
                    pts_y[pt_count] = it.point_y;
                    pt_count++;
                end
            end
            OP_EVAL: begin
                m = wrap_mode ? pt_count + 3 : pt_count;
                few = wrap_mode ? (pt_count < 3) : (pt_count < 4);
                if (few) begin
                    res.status = ST_FEW;
                end else if (it.sample_index >= n_samples) begin
                    res.status = ST_RANGE;
                end else begin
                    num = 64'(it.sample_index) * (m - 3);
                    q = num / n_samples;
                    r = num % n_samples;
                    if (r == 0) begin
                        j = (q < 1) ? 1 : q;
                        t = (q == 0) ? 0 : S1;
                    end else begin
                        j = q + 1;
                        t = (r * S1) / n_samples;
                    end
                    t2 = t * t;
                    t3 = t2 * t;
                    b[0] = (S1 - t) * (S1 - t) * (S1 - t);
                    b[1] = 3 * t3 + 4 * s2 * S1 - 6 * t2 * S1;
                    b[2] = 3 * t2 * S1 + 3 * t * s2 + s2 * S1 - 3 * t3;
                    b[3] = t3;
                    for (int k = 0; k < 4; k++) begin
                        e = j - 1 + k;
                        if (e >= pt_count)
                            e -= pt_count;
                        if (e >= MAXP)
                            e = 0;
                        w[k] = longint'((b[k] + s2 / 2) / s2);
                        px[k] = pts_x[e];
                        py[k] = pts_y[e];
                    end
                    res.curve_x = sat16(blend_coord(w, px));
                    res.curve_y = sat16(blend_coord(w, py));
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic idle_gap();
        int g;
        g = $urandom_range(0, 99);
        if (g < 60)
            return;
        i_in_valid <= 1'b0;
        repeat ((g < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge i_clk);
    endtask

    task automatic send_item(t_in_item it, bit fixed, t_out_item want);
        t_out_item p;
        p = spline_predict(it);
        if (fixed && p != want) begin
            $display("%0t table/predictor disagree exp %h act %h", $time, want, p);
            errors++;
        end
        pending_q = {pending_q, p};
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        idle_gap();
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SAMPLE_COUNT)
            n_samples = val;
        else
            wrap_mode = val[0];
    endtask

    function automatic t_in_item mk(logic [1:0] op, int x, int y, int idx);
        t_in_item it;
        it.opcode = op;
        it.point_x = x[15:0];
        it.point_y = y[15:0];
        it.sample_index = idx[15:0];
        return it;
    endfunction

    function automatic t_in_item rand_item(int p_eval);
        t_in_item it;
        int      sel;
        it.point_x = 16'($urandom());
        it.point_y = 16'($urandom());
        it.sample_index = ($urandom_range(0, 9) == 0) ? 16'($urandom()) :
                          16'($urandom_range(0, n_samples));
        sel = $urandom_range(0, 99);
        if (sel < p_eval)
            it.opcode = OP_EVAL;
        else if (sel < 96)
            it.opcode = OP_APPEND;
        else if (sel < 98)
            it.opcode = OP_CLEAR;
        else
            it.opcode = 2'd3;
        return it;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                $display("%0t unexpected transfer act %h", $time, o_out_data);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (o_out_data.curve_x !== want.curve_x)
                    $display("%0t curve_x exp %0d act %0d", $time, want.curve_x,
                             o_out_data.curve_x);
                if (o_out_data.curve_y !== want.curve_y)
                    $display("%0t curve_y exp %0d act %0d", $time, want.curve_y,
                             o_out_data.curve_y);
                if (o_out_data.status !== want.status)
                    $display("%0t status exp %0d act %0d", $time, want.status,
                             o_out_data.status);
                if (o_out_data !== want)
                    errors++;
            end
        end
    end

    // receiver stalls
    initial begin
        int s;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (600) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_off = 1'b0;
            end else begin
                s = $urandom_range(0, 99);
                if (s < 70)
                    i_out_stall <= 1'b0;
                else if (s < 97)
                    i_out_stall <= 1'b1;
                else begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(10, 60)) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_row      rows[14];
        t_out_item ok0, few, rng, full;
        int        lim;
        ok0 = '0;
        few = '0;
        few.status = ST_FEW;
        rng = '0;
        rng.status = ST_RANGE;
        full = '0;
        full.status = ST_FULL;
        errors = 0;
        hold_off = 1'b0;
        pt_count = 0;
        n_samples = 16'd64;
        wrap_mode = 1'b0;
        for (int k = 0; k < MAXP; k++) begin
            pts_x[k] = '0;
            pts_y[k] = '0;
        end
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows[0]  = '{mk(OP_EVAL, 0, 0, 0), 1, few};
        rows[1]  = '{mk(OP_APPEND, 32767, -32768, 0), 1, ok0};
        rows[2]  = '{mk(OP_APPEND, -32768, 32767, 0), 1, ok0};
        rows[3]  = '{mk(OP_APPEND, 32767, 32767, 0), 1, ok0};
        rows[4]  = '{mk(OP_EVAL, 0, 0, 5), 1, few};
        rows[5]  = '{mk(OP_APPEND, -32768, -32768, 0), 1, ok0};
        rows[6]  = '{mk(OP_EVAL, 0, 0, 0), 0, ok0};
        rows[7]  = '{mk(OP_EVAL, 0, 0, 63), 0, ok0};
        rows[8]  = '{mk(OP_EVAL, 0, 0, 64), 1, rng};
        rows[9]  = '{mk(OP_EVAL, 0, 0, 65535), 1, rng};
        rows[10] = '{mk(OP_EVAL, 0, 0, 32), 0, ok0};
        rows[11] = '{mk(2'd3, -1, -1, 65535), 1, ok0};
        rows[12] = '{mk(OP_CLEAR, 0, 0, 0), 1, ok0};
        rows[13] = '{mk(OP_EVAL, 0, 0, 1), 1, few};
        foreach (rows[r])
            send_item(rows[r].item, rows[r].fixed, rows[r].result);

        // fill the store to overflow
        for (int k = 0; k < MAXP + 2; k++)
            send_item(mk(OP_APPEND, $urandom(), $urandom(), 0), 0, ok0);
        send_item(mk(OP_EVAL, 0, 0, 63), 0, ok0);

        write_reg(CFG_CLOSED_MODE, 16'd1);
        write_reg(CFG_SAMPLE_COUNT, 16'd65535);
        send_item(mk(OP_EVAL, 0, 0, 65534), 0, ok0);
        send_item(mk(OP_EVAL, 0, 0, 65535), 1, rng);
        write_reg(CFG_SAMPLE_COUNT, 16'd1);
        send_item(mk(OP_EVAL, 0, 0, 0), 0, ok0);
        send_item(mk(OP_CLEAR, 0, 0, 0), 1, ok0);
        send_item(mk(OP_APPEND, 5, -5, 0), 1, ok0);
        send_item(mk(OP_APPEND, -7, 7, 0), 1, ok0);
        send_item(mk(OP_EVAL, 0, 0, 0), 1, few);
        send_item(mk(OP_APPEND, 100, 200, 0), 1, ok0);
        send_item(mk(OP_EVAL, 0, 0, 0), 0, ok0);
        write_reg(CFG_SAMPLE_COUNT, 16'd0);
        send_item(mk(OP_EVAL, 0, 0, 0), 1, rng);

        // random phases: curve builds followed by random items, mostly evaluations
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: write_reg(CFG_SAMPLE_COUNT, 16'($urandom_range(1, 100)));
                1: write_reg(CFG_SAMPLE_COUNT, 16'($urandom_range(1, 65535)));
                2: write_reg(CFG_SAMPLE_COUNT, 16'd1);
                default: write_reg(CFG_SAMPLE_COUNT, 16'd65535);
            endcase
            write_reg(CFG_CLOSED_MODE, 16'(ph % 2));
            if (ph == 3)
                hold_off = 1'b1;
            send_item(mk(OP_CLEAR, 0, 0, 0), 0, ok0);
            lim = (ph == 5) ? MAXP + 3 : $urandom_range(3, 12);
            for (int k = 0; k < lim; k++)
                send_item(mk(OP_APPEND, $urandom(), $urandom(), 0), 0, ok0);
            for (int k = 0; k < N_RANDOM / 8; k++)
                send_item(rand_item(75), 0, ok0);
        end
        i_in_valid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
